// ----- sv/npsched_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the nonpreemptive priority scheduler.
// No dependencies.
package npsched_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 22;
    localparam int ID_W    = 6;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_length;
        logic [PRIO_W-1:0]  prio_level;
        logic               final_job;
    } job_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last_result;
    } job_out_t;

    // one word of the job store
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_entry_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } sched_state_t;

endpackage

// ----- sv/nonpreemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// Nonpreemptive priority scheduler: job store memory, scan sequencer, result register.
// Depends on npsched_pkg.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | npsched_pkg::job_in_t  (one job)
//  m_      | out       | m_valid / m_ready  | npsched_pkg::job_out_t (one scheduled job)
//
// Loading accepts one item per cycle. A batch of N jobs yields N results, each after a
// scan of all N store entries through the one read port. s_ready is high only while
// loading. Reset (aresetn low, synchronous) clears the counters, done flags and the
// result valid; the store memory is not cleared. A stalled result holds the sequencer
// in its emit step; the next batch may be loaded while the last result waits.
module nonpreemptive_priority_scheduler #(
    parameter int MAX_JOBS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  npsched_pkg::job_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output npsched_pkg::job_out_t m_data
);
    import npsched_pkg::*;

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    // job store
    job_entry_t mem [MAX_JOBS];
    job_entry_t mem_q_reg;

    sched_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] k_reg, k_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [TIME_W-1:0] clock_reg, clock_next;
    logic [MAX_JOBS-1:0] done_reg, done_next;

    // best arrived job: prio, then arrival, then lower index
    logic              found_a_reg, found_a_next;
    job_entry_t        cand_a_reg, cand_a_next;
    logic [IW-1:0]     idx_a_reg, idx_a_next;
    // earliest not yet arrived job: arrival, then prio, then lower index
    logic              found_n_reg, found_n_next;
    job_entry_t        cand_n_reg, cand_n_next;
    logic [IW-1:0]     idx_n_reg, idx_n_next;

    // chosen job
    job_entry_t        sel_reg, sel_next;
    logic [IW-1:0]     sel_idx_reg, sel_idx_next;
    logic [TIME_W-1:0] start_reg, start_next;

    logic     m_valid_reg, m_valid_next;
    job_out_t m_data_reg, m_data_next;

    logic          s_fire, full, emit_fire, is_last;
    logic          elig_a, elig_n, better_a, better_n;
    logic [TIME_W-1:0] arr_ext;
    logic [IW-1:0] rd_addr;

    assign s_ready   = (state_reg == ST_LOAD);
    assign s_fire    = s_valid && s_ready;
    assign full      = (count_reg == CW'(MAX_JOBS));
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign is_last   = (CW'(k_reg + 1'b1) == total_reg);
    assign rd_addr   = issue_reg[IW-1:0];
    assign arr_ext   = TIME_W'(mem_q_reg.arrival);

    assign elig_a   = rd_valid_reg && !done_reg[rd_idx_reg] && (arr_ext <= clock_reg);
    assign elig_n   = rd_valid_reg && !done_reg[rd_idx_reg] && (arr_ext > clock_reg);
    assign better_a = !found_a_reg || (mem_q_reg.prio < cand_a_reg.prio) ||
                      ((mem_q_reg.prio == cand_a_reg.prio) &&
                       (mem_q_reg.arrival < cand_a_reg.arrival));
    assign better_n = !found_n_reg || (mem_q_reg.arrival < cand_n_reg.arrival) ||
                      ((mem_q_reg.arrival == cand_n_reg.arrival) &&
                       (mem_q_reg.prio < cand_n_reg.prio));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        issue_next    = issue_reg;
        k_next        = k_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_addr;
        clock_next    = clock_reg;
        done_next     = done_reg;
        found_a_next  = found_a_reg;
        cand_a_next   = cand_a_reg;
        idx_a_next    = idx_a_reg;
        found_n_next  = found_n_reg;
        cand_n_next   = cand_n_reg;
        idx_n_next    = idx_n_reg;
        sel_next      = sel_reg;
        sel_idx_next  = sel_idx_reg;
        start_next    = start_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (!full) begin
                        count_next = CW'(count_reg + 1'b1);
                    end
                    if (s_data.final_job) begin
                        total_next   = full ? count_reg : CW'(count_reg + 1'b1);
                        clock_next   = '0;
                        k_next       = '0;
                        issue_next   = '0;
                        found_a_next = 1'b0;
                        found_n_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg != total_reg) begin
                    issue_next    = CW'(issue_reg + 1'b1);
                    rd_valid_next = 1'b1;
                end
                if (elig_a && better_a) begin
                    found_a_next = 1'b1;
                    cand_a_next  = mem_q_reg;
                    idx_a_next   = rd_idx_reg;
                end
                if (elig_n && better_n) begin
                    found_n_next = 1'b1;
                    cand_n_next  = mem_q_reg;
                    idx_n_next   = rd_idx_reg;
                end
                if (issue_reg == total_reg && !rd_valid_reg) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                // nothing arrived: clock jumps to the earliest pending arrival
                if (found_a_reg) begin
                    sel_next     = cand_a_reg;
                    sel_idx_next = idx_a_reg;
                    start_next   = clock_reg;
                    clock_next   = clock_reg + TIME_W'(cand_a_reg.burst);
                end else begin
                    sel_next     = cand_n_reg;
                    sel_idx_next = idx_n_reg;
                    start_next   = TIME_W'(cand_n_reg.arrival);
                    clock_next   = TIME_W'(cand_n_reg.arrival) + TIME_W'(cand_n_reg.burst);
                end
                done_next[found_a_reg ? idx_a_reg : idx_n_reg] = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next             = 1'b1;
                    m_data_next.job_id       = ID_W'({{(32 - IW){1'b0}}, sel_idx_reg} + 32'd1);
                    m_data_next.start_time   = start_reg;
                    m_data_next.finish_time  = clock_reg;
                    m_data_next.turnaround   = clock_reg - TIME_W'(sel_reg.arrival);
                    // turnaround - burst equals start - arrival
                    m_data_next.waiting      = start_reg - TIME_W'(sel_reg.arrival);
                    m_data_next.last_result  = is_last;
                    found_a_next = 1'b0;
                    found_n_next = 1'b0;
                    issue_next   = '0;
                    if (is_last) begin
                        done_next  = '0;
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = CW'(k_reg + 1'b1);
                        state_next = ST_SCAN;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            total_reg    <= '0;
            issue_reg    <= '0;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            clock_reg    <= '0;
            done_reg     <= '0;
            found_a_reg  <= 1'b0;
            found_n_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            issue_reg    <= issue_next;
            k_reg        <= k_next;
            rd_valid_reg <= rd_valid_next;
            clock_reg    <= clock_next;
            done_reg     <= done_next;
            found_a_reg  <= found_a_next;
            found_n_reg  <= found_n_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        cand_a_reg  <= cand_a_next;
        idx_a_reg   <= idx_a_next;
        cand_n_reg  <= cand_n_next;
        idx_n_reg   <= idx_n_next;
        sel_reg     <= sel_next;
        sel_idx_reg <= sel_idx_next;
        start_reg   <= start_next;
        m_data_reg  <= m_data_next;
    end

    // store: written while loading, read while scanning
    always_ff @(posedge aclk) begin
        if (s_fire && !full) begin
            mem[count_reg[IW-1:0]] <= '{arrival: s_data.arrival_time,
                                       burst:   s_data.burst_length,
                                       prio:    s_data.prio_level};
        end
        mem_q_reg <= mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_JOBS))
        else $error("job count exceeds store depth");

    a_calc_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CALC |-> (found_a_reg || found_n_reg))
        else $error("selection finished with no unfinished job");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit step");

    a_batch_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && is_last) |=> (done_reg == '0 && count_reg == '0))
        else $error("batch end left state behind");

endmodule
